// File: rtl/rcpd_pkg.sv
// ----------------------------------------------------------------------------
// rcpd_pkg
// Shared types and constants for the RC PWM pulse decoder with failsafe.
// ----------------------------------------------------------------------------
package rcpd_pkg;

    // stream payload layout
    localparam int S_TDATA_W = 40;  // channel, level, timestamp (35 bits used)
    localparam int S_TUSER_W = 1;   // command
    localparam int M_TDATA_W = 56;  // four widths, link_ok, pulse_accepted

    localparam int TS_W   = 32;
    localparam int DIV_W  = 8;
    localparam int WID_W  = 12;
    localparam int QUO_W  = 16;
    localparam int CH_W   = 2;
    localparam int OUT_CH = 4;

    // APB register file
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_TICKS_PER_US = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_WIDTH    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_WIDTH    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FAILSAFE_CH0 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FAILSAFE_CH1 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FAILSAFE_CH2 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FAILSAFE_CH3 = 3'd6;

    localparam logic [DIV_W-1:0] RST_TICKS_PER_US = 8'd72;
    localparam logic [WID_W-1:0] RST_MIN_WIDTH    = 12'd800;
    localparam logic [WID_W-1:0] RST_MAX_WIDTH    = 12'd2200;
    localparam logic [WID_W-1:0] RST_FAILSAFE_HI  = 12'd1500;
    localparam logic [WID_W-1:0] RST_FAILSAFE_LO  = 12'd1000;

    // input command codes
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic [DIV_W-1:0]             ticks_per_us;
        logic [WID_W-1:0]             min_width;
        logic [WID_W-1:0]             max_width;
        logic [OUT_CH-1:0][WID_W-1:0] failsafe;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// File: rtl/rcpd_cfg.sv
// ----------------------------------------------------------------------------
// rcpd_cfg
// APB register file: divisor, width window and per-channel failsafe widths.
// ----------------------------------------------------------------------------
module rcpd_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rcpd_pkg::APB_AW-1:0] paddr,
    input  logic [rcpd_pkg::APB_DW-1:0] pwdata,
    output logic [rcpd_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output rcpd_pkg::cfg_t              cfg
);
    import rcpd_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_TICKS_PER_US: cfg_next.ticks_per_us = pwdata[DIV_W-1:0];
                REG_MIN_WIDTH:    cfg_next.min_width    = pwdata[WID_W-1:0];
                REG_MAX_WIDTH:    cfg_next.max_width    = pwdata[WID_W-1:0];
                REG_FAILSAFE_CH0: cfg_next.failsafe[0]  = pwdata[WID_W-1:0];
                REG_FAILSAFE_CH1: cfg_next.failsafe[1]  = pwdata[WID_W-1:0];
                REG_FAILSAFE_CH2: cfg_next.failsafe[2]  = pwdata[WID_W-1:0];
                REG_FAILSAFE_CH3: cfg_next.failsafe[3]  = pwdata[WID_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_us <= RST_TICKS_PER_US;
            cfg_reg.min_width    <= RST_MIN_WIDTH;
            cfg_reg.max_width    <= RST_MAX_WIDTH;
            cfg_reg.failsafe[0]  <= RST_FAILSAFE_HI;
            cfg_reg.failsafe[1]  <= RST_FAILSAFE_HI;
            cfg_reg.failsafe[2]  <= RST_FAILSAFE_LO;
            cfg_reg.failsafe[3]  <= RST_FAILSAFE_LO;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_TICKS_PER_US: prdata = APB_DW'(cfg_reg.ticks_per_us);
            REG_MIN_WIDTH:    prdata = APB_DW'(cfg_reg.min_width);
            REG_MAX_WIDTH:    prdata = APB_DW'(cfg_reg.max_width);
            REG_FAILSAFE_CH0: prdata = APB_DW'(cfg_reg.failsafe[0]);
            REG_FAILSAFE_CH1: prdata = APB_DW'(cfg_reg.failsafe[1]);
            REG_FAILSAFE_CH2: prdata = APB_DW'(cfg_reg.failsafe[2]);
            REG_FAILSAFE_CH3: prdata = APB_DW'(cfg_reg.failsafe[3]);
            default:          prdata = '0;
        endcase
    end

endmodule

// File: rtl/rcpd_div.sv
// ----------------------------------------------------------------------------
// rcpd_div
// Radix-2 restoring divider, 32-bit dividend by 8-bit divisor, one bit/cycle.
// ----------------------------------------------------------------------------
module rcpd_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rcpd_pkg::TS_W-1:0]  dividend,
    input  logic [rcpd_pkg::DIV_W-1:0] divisor,
    output logic [rcpd_pkg::QUO_W-1:0] quotient,
    output rcpd_pkg::div_stat_t        stat
);
    import rcpd_pkg::*;

    localparam int CNT_W = $clog2(TS_W);

    logic [TS_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;

    // shift in the next dividend bit; a zero divisor always subtracts -> all ones
    assign trial = {rem_reg, quo_reg[TS_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[TS_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[TS_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(TS_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient = quo_reg[QUO_W-1:0];
    assign stat     = '{busy: busy_reg, done: done_reg};

endmodule

// File: rtl/rc_pwm_pulse_decoder_failsafe_core.sv
// ----------------------------------------------------------------------------
// rc_pwm_pulse_decoder_failsafe_core
// RC receiver PWM width decoder with silence counters and link-loss failsafe.
// ----------------------------------------------------------------------------
// Sequence: a falling edge on a live channel goes from accept through ST_LOAD,
//   the 32-step bit-serial divider in ST_DIV and ST_DONE to m_tvalid; tick,
//   rising edge and ignored edges go from accept straight to ST_DONE.
// Throughput: one transaction in flight; next accept the cycle after commit.
// Reset (rst_n async, low): registers to defaults, widths to failsafe, counters
//   saturated (link lost), edge starts zero.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_decoder_failsafe_core
#(
    parameter int NUM_CHANNELS = 4,
    parameter int SILENCE_BITS = 4
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] channel, [2] level, [34:3] timestamp, [39:35] zero
    input  logic [rcpd_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] command
    input  logic [rcpd_pkg::S_TUSER_W-1:0] s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [11:0] width_ch0, [23:12] width_ch1, [35:24] width_ch2, [47:36] width_ch3,
    // [48] link_ok, [49] pulse_accepted, [55:50] zero
    output logic [rcpd_pkg::M_TDATA_W-1:0] m_tdata,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rcpd_pkg::APB_AW-1:0]    paddr,
    input  logic [rcpd_pkg::APB_DW-1:0]    pwdata,
    output logic [rcpd_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import rcpd_pkg::*;

    // only four channels can be addressed by an edge and shown on the output
    localparam int CH_STORE = (NUM_CHANNELS < OUT_CH) ? NUM_CHANNELS : OUT_CH;
    localparam logic [SILENCE_BITS-1:0] SIL_MAX = '1;

    cfg_t      cfg;
    div_stat_t div_stat;
    logic      div_start;
    logic [QUO_W-1:0] quotient;
    logic [TS_W-1:0]  div_dividend;

    state_t state_reg, state_next;

    // latched item
    logic            cmd_reg;
    logic [CH_W-1:0] ch_reg;
    logic            level_reg;
    logic [TS_W-1:0] ts_reg;

    // channel state
    logic [TS_W-1:0]         edge_start_reg [CH_STORE];
    logic [WID_W-1:0]        width_reg      [CH_STORE];
    logic [WID_W-1:0]        width_next     [CH_STORE];
    logic [SILENCE_BITS-1:0] sil_reg        [NUM_CHANNELS];
    logic [SILENCE_BITS-1:0] sil_next       [NUM_CHANNELS];

    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tvalid_reg;

    logic            commit;
    logic            in_accept;
    logic            ch_live;
    logic            is_fall;
    logic            acc;
    logic            link_cur;
    logic            link_new;
    logic [TS_W-1:0] start_sel;

    // ------------------------------------------------------------------
    // sub-blocks
    // ------------------------------------------------------------------
    rcpd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rcpd_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cfg.ticks_per_us),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // ------------------------------------------------------------------
    // item decode
    // ------------------------------------------------------------------
    assign in_accept = s_tvalid && s_tready;
    assign ch_live   = (32'(ch_reg) < NUM_CHANNELS);
    assign is_fall   = (cmd_reg == CMD_EDGE) && !level_reg && ch_live;

    always_comb
    begin
        start_sel = '0;
        for (int i = 0; i < CH_STORE; i++)
        begin
            if (ch_reg == CH_W'(i))
            begin
                start_sel = edge_start_reg[i];
            end
        end
    end

    // wrapped tick difference since the rising edge
    assign div_dividend = ts_reg - start_sel;

    // width window check on the truncated 16-bit quotient
    assign acc = is_fall && (quotient > QUO_W'(cfg.min_width))
                         && (quotient < QUO_W'(cfg.max_width));

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        div_start  = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    // only a falling edge on a live channel needs the divider
                    if ((s_tuser[0] == CMD_EDGE) && !s_tdata[2]
                        && (32'(s_tdata[1:0]) < NUM_CHANNELS))
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_LOAD:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the update until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg   <= s_tuser[0];
            ch_reg    <= s_tdata[1:0];
            level_reg <= s_tdata[2];
            ts_reg    <= s_tdata[34:3];
        end
    end

    // ------------------------------------------------------------------
    // channel state update
    // ------------------------------------------------------------------
    always_comb
    begin
        link_cur = 1'b1;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (sil_reg[i] == SIL_MAX)
            begin
                link_cur = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < CH_STORE; i++)
        begin
            width_next[i] = width_reg[i];
        end
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            sil_next[i] = sil_reg[i];
        end
        if (cmd_reg == CMD_TICK)
        begin
            if (link_cur)
            begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    sil_next[i] = sil_reg[i] + SILENCE_BITS'(1);
                end
            end
            else
            begin
                for (int i = 0; i < CH_STORE; i++)
                begin
                    width_next[i] = cfg.failsafe[i];
                end
            end
        end
        else if (acc)
        begin
            for (int i = 0; i < CH_STORE; i++)
            begin
                if (ch_reg == CH_W'(i))
                begin
                    width_next[i] = quotient[WID_W-1:0];
                    sil_next[i]   = '0;
                end
            end
        end
    end

    always_comb
    begin
        link_new = 1'b1;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (sil_next[i] == SIL_MAX)
            begin
                link_new = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CH_STORE; i++)
            begin
                edge_start_reg[i] <= '0;
                width_reg[i]      <= (i < 2) ? RST_FAILSAFE_HI : RST_FAILSAFE_LO;
            end
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                sil_reg[i] <= SIL_MAX;
            end
        end
        else if (commit)
        begin
            for (int i = 0; i < CH_STORE; i++)
            begin
                width_reg[i] <= width_next[i];
                if ((cmd_reg == CMD_EDGE) && level_reg && (ch_reg == CH_W'(i)))
                begin
                    edge_start_reg[i] <= ts_reg;
                end
            end
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                sil_reg[i] <= sil_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_comb
    begin
        m_tdata_next = '0;
        for (int i = 0; i < CH_STORE; i++)
        begin
            m_tdata_next[i*WID_W +: WID_W] = width_next[i];
        end
        m_tdata_next[OUT_CH*WID_W]     = link_new;
        m_tdata_next[OUT_CH*WID_W + 1] = acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_stat.busy)
        else $error("input ready while the divider is busy");

    a_acc_only_fall: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && acc) |-> (cmd_reg == CMD_EDGE) && !level_reg)
        else $error("pulse accepted on an item that is not a falling edge");

    a_acc_clears_link: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && acc && (NUM_CHANNELS == 1)) |=> m_tdata[OUT_CH*WID_W])
        else $error("accepted pulse on the only channel left the link down");

endmodule
